// ----- sv/pht_pkg.sv -----
// Shared types, constants and helper functions of the pair HMM count trainer.
`default_nettype none
package pht_pkg;

  localparam int ALPHABET    = 8;
  localparam int COUNT_BITS  = 32;
  localparam int SYM_W       = 3;
  localparam int STATE_W     = 2;
  localparam int KIND_W      = 2;
  localparam int OUT_W       = 32;
  localparam int TRANS_DEPTH = 16;
  localparam int TRANS_AW    = 2 * STATE_W;
  localparam int EMIT_DEPTH  = 4 * ALPHABET * ALPHABET;
  localparam int EMIT_AW     = $clog2(EMIT_DEPTH);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W   = 2;

  localparam logic [KIND_W-1:0] KIND_COLUMN     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ_TRANS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ_EMIT  = 2'd2;

  localparam logic [STATE_W-1:0] STATE_BEGIN = 2'd0;
  localparam logic [STATE_W-1:0] ST_MATCH    = 2'd1;
  localparam logic [STATE_W-1:0] ST_INSERT   = 2'd2;
  localparam logic [STATE_W-1:0] ST_DELETE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_CODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_CODE = 2'd1;

  localparam logic [SYM_W-1:0] GAP_CODE_RESET     = 3'd4;
  localparam logic [SYM_W-1:0] INVALID_CODE_RESET = 3'd7;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [1:0] {
    OP_COLUMN,
    OP_READ_TRANS,
    OP_READ_EMIT
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [STATE_W-1:0]   st;
    logic                 first;
    logic                 last;
    logic [TRANS_AW-1:0]  trans_idx;
    logic [EMIT_AW-1:0]   emit_addr;
    logic                 emit_ok;
  } item_t;

  function automatic logic sym_in_alpha(input logic [SYM_W-1:0] s);
    return int'(s) < ALPHABET;
  endfunction

  function automatic logic [EMIT_AW-1:0] emit_index(input logic [STATE_W-1:0] st,
                                                    input logic [SYM_W-1:0] r,
                                                    input logic [SYM_W-1:0] c);
    return EMIT_AW'((EMIT_AW'(st) * EMIT_AW'(ALPHABET) + EMIT_AW'(r)) * EMIT_AW'(ALPHABET)
                    + EMIT_AW'(c));
  endfunction

  function automatic count_t sat_bump(input count_t c);
    return (c == '1) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    if (w > 64'h0000_0000_FFFF_FFFF) return '1;
    return w[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/pht_fifo.sv -----
// Two-entry queue of classified transactions between front and back.
`default_nettype none
module pht_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire pht_pkg::item_t push_item_i,
  input  wire logic          pop_i,
  output pht_pkg::item_t     head_o,
  output logic               empty_o,
  output logic               full_o
);
  import pht_pkg::*;

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]      cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_cnt_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !push_i |=> cnt_q == $past(cnt_q) - 1'b1) else $error("queue count lost");

endmodule
`default_nettype wire

// ----- sv/pht_front.sv -----
// Front end: configuration registers, acceptance and classification of transactions.
`default_nettype none
module pht_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [pht_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pht_pkg::SYM_W-1:0]      cfg_data_i,
  input  wire logic                           in_valid_i,
  input  wire logic [pht_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [pht_pkg::SYM_W-1:0]      sym_top_i,
  input  wire logic [pht_pkg::SYM_W-1:0]      sym_bottom_i,
  input  wire logic                           first_column_i,
  input  wire logic                           last_column_i,
  input  wire logic [pht_pkg::STATE_W-1:0]    from_state_i,
  input  wire logic [pht_pkg::STATE_W-1:0]    to_state_i,
  input  wire logic                           full_i,
  output logic                                push_o,
  output pht_pkg::item_t                      item_o
);
  import pht_pkg::*;

  logic [SYM_W-1:0]   gap_q, invalid_q;
  logic [STATE_W-1:0] st;
  logic [SYM_W-1:0]   et, eb;
  logic               accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q     <= GAP_CODE_RESET;
      invalid_q <= INVALID_CODE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GAP_CODE:     gap_q     <= cfg_data_i;
        CFG_INVALID_CODE: invalid_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sym_top_i == gap_q)         st = ST_INSERT;
    else if (sym_bottom_i == gap_q) st = ST_DELETE;
    else                            st = ST_MATCH;
    et = (sym_top_i == invalid_q || !sym_in_alpha(sym_top_i)) ? gap_q : sym_top_i;
    eb = (sym_bottom_i == invalid_q || !sym_in_alpha(sym_bottom_i)) ? gap_q : sym_bottom_i;
  end

  assign accept = in_valid_i && !full_i;

  always_comb begin
    item_o.op        = OP_COLUMN;
    item_o.st        = st;
    item_o.first     = first_column_i;
    item_o.last      = last_column_i;
    item_o.trans_idx = {from_state_i, to_state_i};
    item_o.emit_addr = emit_index(st, et, eb);
    item_o.emit_ok   = sym_in_alpha(et) && sym_in_alpha(eb);
    push_o           = 1'b0;
    case (kind_i)
      KIND_COLUMN: begin
        push_o = accept;
      end
      KIND_READ_TRANS: begin
        item_o.op = OP_READ_TRANS;
        push_o    = accept;
      end
      KIND_READ_EMIT: begin
        item_o.op        = OP_READ_EMIT;
        item_o.emit_addr = emit_index(from_state_i, sym_top_i, sym_bottom_i);
        item_o.emit_ok   = sym_in_alpha(sym_top_i) && sym_in_alpha(sym_bottom_i);
        push_o           = accept;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/pht_back.sv -----
// Back end: transition counters, emission count memory with forwarding, result register.
`default_nettype none
module pht_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire pht_pkg::item_t             head_i,
  input  wire logic                       empty_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [pht_pkg::OUT_W-1:0]       count_value_o
);
  import pht_pkg::*;

  count_t              trans_q [TRANS_DEPTH];
  logic [STATE_W-1:0]  prev_q;
  count_t              emit_mem [EMIT_DEPTH];
  logic [EMIT_DEPTH-1:0] ev_q;

  logic                s2_vld_q;
  item_t               s2_q;
  count_t              trans_rd_q, em_rd_q;
  logic                ev_rd_q;
  logic                lw_vld_q;
  logic [EMIT_AW-1:0]  lw_addr_q;
  count_t              lw_data_q;
  logic                out_vld_q;
  logic [OUT_W-1:0]    out_q;

  logic                issue, s2_read, s2_adv, wr_en;
  logic [TRANS_AW-1:0] idx_a, idx_b;
  count_t              base, bumped;
  logic [OUT_W-1:0]    result;

  assign s2_read = (s2_q.op != OP_COLUMN);
  assign s2_adv  = !s2_read || !out_vld_q || !out_stall_i;
  assign issue   = !empty_i && (!s2_vld_q || s2_adv);
  assign pop_o   = issue;
  assign idx_a   = head_i.first ? {STATE_BEGIN, head_i.st} : {prev_q, head_i.st};
  assign idx_b   = {head_i.st, STATE_BEGIN};

  always_comb begin
    if (lw_vld_q && lw_addr_q == s2_q.emit_addr) base = lw_data_q;
    else if (ev_rd_q)                            base = em_rd_q;
    else                                         base = '0;
    bumped = sat_bump(base);
    wr_en  = s2_vld_q && s2_adv && (s2_q.op == OP_COLUMN) && s2_q.emit_ok;
    case (s2_q.op)
      OP_READ_TRANS: result = to_out(trans_rd_q);
      OP_READ_EMIT:  result = s2_q.emit_ok ? to_out(base) : '0;
      default:       result = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_q <= '{default: '0};
      prev_q  <= STATE_BEGIN;
    end else if (issue && head_i.op == OP_COLUMN) begin
      for (int i = 0; i < TRANS_DEPTH; i++) begin
        if (idx_a == TRANS_AW'(i) || (head_i.last && idx_b == TRANS_AW'(i))) begin
          trans_q[i] <= sat_bump(trans_q[i]);
        end
      end
      prev_q <= head_i.last ? STATE_BEGIN : head_i.st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) emit_mem[s2_q.emit_addr] <= bumped;
    if (issue) em_rd_q <= emit_mem[head_i.emit_addr];
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_q       <= head_i;
      trans_rd_q <= trans_q[head_i.trans_idx];
      ev_rd_q    <= ev_q[head_i.emit_addr];
    end
    if (wr_en) begin
      lw_addr_q <= s2_q.emit_addr;
      lw_data_q <= bumped;
    end
    if (s2_vld_q && s2_adv && s2_read) out_q <= result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q      <= '0;
      lw_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        ev_q[s2_q.emit_addr] <= 1'b1;
        lw_vld_q             <= 1'b1;
      end
      if (issue)       s2_vld_q <= 1'b1;
      else if (s2_adv) s2_vld_q <= 1'b0;
      if (s2_vld_q && s2_adv && s2_read) out_vld_q <= 1'b1;
      else if (!out_stall_i)             out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign count_value_o = out_q;

  a_prev_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && head_i.op == OP_COLUMN && head_i.last |=> prev_q == STATE_BEGIN)
    else $error("state not returned to begin after last column");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(out_q))
    else $error("result overwritten while stalled");
  a_wr_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> s2_q.op == OP_COLUMN && s2_vld_q)
    else $error("emission write from a read transaction");

endmodule
`default_nettype wire

// ----- sv/pair_hmm_count_trainer.sv -----
// Pair HMM three-state count trainer: top level.
// Input channel (in_valid_i / in_stall_o) takes one transaction per cycle unless
// stalled: a column pair (kind 0), a transition count read (kind 1) or an emission
// count read (kind 2). Kind 3 is accepted and dropped. Columns produce no result;
// each read produces one count_value_o on the output channel (out_valid_o /
// out_stall_i). A read result passes from the queue through the issue stage (emission
// memory read) into the result register.
// Throughput: one transaction per cycle while no read waits on a stalled output; the
// emission read-modify-write is a two stage pipeline with forwarding from the last
// write, so repeated columns to the same counter do not slow down.
// A stalled result holds in the output register; the back end retires columns until a
// read reaches it, then the two-entry queue fills, raising in_stall_o only when full.
// Configuration (cfg_valid_i / cfg_ready_o, always ready) writes gap_code (index 0)
// and invalid_code (index 1); writes are expected only while the block is idle.
// Reset clears all counters at once (valid bits on the emission memory), the
// previous state to begin, and restores gap_code 4 and invalid_code 7.
`default_nettype none
module pair_hmm_count_trainer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pht_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pht_pkg::SYM_W-1:0]      cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pht_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [pht_pkg::SYM_W-1:0]      sym_top_i,
  input  wire logic [pht_pkg::SYM_W-1:0]      sym_bottom_i,
  input  wire logic                           first_column_i,
  input  wire logic                           last_column_i,
  input  wire logic [pht_pkg::STATE_W-1:0]    from_state_i,
  input  wire logic [pht_pkg::STATE_W-1:0]    to_state_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [pht_pkg::OUT_W-1:0]           count_value_o
);
  import pht_pkg::*;

  item_t push_item, head;
  logic  push, pop, empty, full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  pht_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .kind_i         (kind_i),
    .sym_top_i      (sym_top_i),
    .sym_bottom_i   (sym_bottom_i),
    .first_column_i (first_column_i),
    .last_column_i  (last_column_i),
    .from_state_i   (from_state_i),
    .to_state_i     (to_state_i),
    .full_i         (full),
    .push_o         (push),
    .item_o         (push_item)
  );

  pht_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  pht_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .count_value_o (count_value_o)
  );

endmodule
`default_nettype wire
